// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent checks, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- design/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg
// widths, constants and types shared by the rgb to hsv converter
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int CHAN_W       = CHANNEL_BITS;
  localparam int QUO_W        = (CHAN_W > 12) ? CHAN_W : 12;
  localparam int NUM_W        = CHAN_W + QUO_W;
  localparam int HUE_W        = 15;
  localparam int HUE_CALC_W   = HUE_W + 1;
  localparam int DIV_STAGES   = QUO_W;
  localparam int PIPE_STAGES  = DIV_STAGES + 3;

  localparam int CHAN_FULL  = (1 << CHANNEL_BITS) - 1;
  localparam int HUE_SIXTY  = 3840;
  localparam int HUE_GREEN  = 2 * HUE_SIXTY;
  localparam int HUE_BLUE   = 4 * HUE_SIXTY;
  localparam int HUE_TURN   = 6 * HUE_SIXTY;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [QUO_W-1:0]  work;
    logic [CHAN_W-1:0] den;
  } div_lane_t;

  typedef struct packed {
    sector_t           sector;
    logic              neg;
    logic              defined;
    logic [CHAN_W-1:0] bright;
  } side_t;

endpackage

`default_nettype wire

// ----- design/rhc_div.sv -----
// ----------------------------------------------------------------------------
// rhc_div
// two-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div (
  input  wire logic                        clk,
  input  wire logic [rhc_pkg::DIV_STAGES-1:0] en,
  input  wire logic [rhc_pkg::NUM_W-1:0]   num_sat,
  input  wire logic [rhc_pkg::CHAN_W-1:0]  den_sat,
  input  wire logic [rhc_pkg::NUM_W-1:0]   num_hue,
  input  wire logic [rhc_pkg::CHAN_W-1:0]  den_hue,
  input  wire rhc_pkg::side_t              side_in,
  output logic      [rhc_pkg::QUO_W-1:0]   quo_sat,
  output logic      [rhc_pkg::QUO_W-1:0]   quo_hue,
  output logic                             rem_hue_nz,
  output rhc_pkg::side_t                   side_out
);

  rhc_pkg::div_lane_t sat_lane [rhc_pkg::DIV_STAGES];
  rhc_pkg::div_lane_t hue_lane [rhc_pkg::DIV_STAGES];
  rhc_pkg::side_t     side_q   [rhc_pkg::DIV_STAGES];

  rhc_pkg::div_lane_t sat_init;
  rhc_pkg::div_lane_t hue_init;

  function automatic rhc_pkg::div_lane_t div_step(input rhc_pkg::div_lane_t l);
    logic [rhc_pkg::CHAN_W:0] trial;
    logic                     ge;
    rhc_pkg::div_lane_t       o;
    trial  = {l.rem, l.work[rhc_pkg::QUO_W-1]};
    ge     = trial >= {1'b0, l.den};
    o.den  = l.den;
    o.rem  = ge ? rhc_pkg::CHAN_W'(trial - {1'b0, l.den})
                : trial[rhc_pkg::CHAN_W-1:0];
    o.work = {l.work[rhc_pkg::QUO_W-2:0], ge};
    return o;
  endfunction

  always_comb begin
    sat_init.rem  = num_sat[rhc_pkg::NUM_W-1:rhc_pkg::QUO_W];
    sat_init.work = num_sat[rhc_pkg::QUO_W-1:0];
    sat_init.den  = den_sat;
    hue_init.rem  = num_hue[rhc_pkg::NUM_W-1:rhc_pkg::QUO_W];
    hue_init.work = num_hue[rhc_pkg::QUO_W-1:0];
    hue_init.den  = den_hue;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sat_lane[0] <= div_step(sat_init);
      hue_lane[0] <= div_step(hue_init);
      side_q[0]   <= side_in;
    end
    for (int i = 1; i < rhc_pkg::DIV_STAGES; i++) begin
      if (en[i]) begin
        sat_lane[i] <= div_step(sat_lane[i-1]);
        hue_lane[i] <= div_step(hue_lane[i-1]);
        side_q[i]   <= side_q[i-1];
      end
    end
  end

  assign quo_sat    = sat_lane[rhc_pkg::DIV_STAGES-1].work;
  assign quo_hue    = hue_lane[rhc_pkg::DIV_STAGES-1].work;
  assign rem_hue_nz = hue_lane[rhc_pkg::DIV_STAGES-1].rem != '0;
  assign side_out   = side_q[rhc_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- design/rgb_to_hsv_convert.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert
// rgb pixel to hue, saturation and value, fully pipelined
// ----------------------------------------------------------------------------
// Takes one pixel per clock while pixel_stall is low: one stage
// finds max, min and the hue sector, one forms the scaled numerators, twelve
// stages of a restoring divider produce one quotient bit each for saturation
// and hue at once, and a last stage applies sector offset, sign and wrap.
// Hue is in 1/64 degree; black and gray give hue 0 with hue_defined low.
// Stages advance independently, so bubbles close up behind a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rgb_to_hsv_convert (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       pixel_valid,
  output logic                            pixel_stall,
  input  wire logic [rhc_pkg::CHAN_W-1:0] red,
  input  wire logic [rhc_pkg::CHAN_W-1:0] green,
  input  wire logic [rhc_pkg::CHAN_W-1:0] blue,
  output logic                            hsv_valid,
  input  wire logic                       hsv_stall,
  output logic      [rhc_pkg::HUE_W-1:0]  hue,
  output logic      [rhc_pkg::CHAN_W-1:0] saturation,
  output logic      [rhc_pkg::CHAN_W-1:0] brightness,
  output logic                            hue_defined
);

  localparam int LAST = rhc_pkg::PIPE_STAGES - 1;

  logic [rhc_pkg::PIPE_STAGES-1:0] vld;
  logic [rhc_pkg::PIPE_STAGES-1:0] en;

  // stage 0 compute
  logic [rhc_pkg::CHAN_W-1:0] mx, mn;
  rhc_pkg::sector_t           sect;
  logic signed [rhc_pkg::CHAN_W:0] diff;

  // stage 0 registers
  logic [rhc_pkg::CHAN_W-1:0] s0_mx;
  logic [rhc_pkg::CHAN_W-1:0] s0_delta;
  logic [rhc_pkg::CHAN_W-1:0] s0_abs;
  logic                       s0_neg;
  rhc_pkg::sector_t           s0_sect;

  // stage 1 registers
  logic [rhc_pkg::NUM_W-1:0]  s1_num_sat, s1_num_hue;
  logic [rhc_pkg::CHAN_W-1:0] s1_den_sat, s1_den_hue;
  rhc_pkg::side_t             s1_side;

  // divider outputs
  logic [rhc_pkg::QUO_W-1:0]  quo_sat, quo_hue;
  logic                       rem_hue_nz;
  rhc_pkg::side_t             dv_side;

  // final compute
  logic signed [rhc_pkg::HUE_CALC_W-1:0] frac, base, hue_sum, hue_fix;

  always_comb begin
    en[LAST] = !vld[LAST] || !hsv_stall;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign pixel_stall = !en[0];
  assign hsv_valid   = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= pixel_valid;
      end
      for (int i = 1; i < rhc_pkg::PIPE_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    priority if (red == mx) begin
      sect = rhc_pkg::SECT_RED;
      diff = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green == mx) begin
      sect = rhc_pkg::SECT_GREEN;
      diff = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sect = rhc_pkg::SECT_BLUE;
      diff = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_mx    <= mx;
      s0_delta <= mx - mn;
      s0_neg   <= diff[rhc_pkg::CHAN_W];
      s0_abs   <= diff[rhc_pkg::CHAN_W] ? rhc_pkg::CHAN_W'(-diff)
                                        : diff[rhc_pkg::CHAN_W-1:0];
      s0_sect  <= sect;
    end
  end

  // zero divisors become one with a zero numerator, so the quotient is zero
  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (s0_mx == '0) begin
        s1_num_sat <= '0;
        s1_den_sat <= rhc_pkg::CHAN_W'(1);
      end else begin
        s1_num_sat <= rhc_pkg::NUM_W'(rhc_pkg::CHAN_FULL) * rhc_pkg::NUM_W'(s0_delta);
        s1_den_sat <= s0_mx;
      end
      if (s0_delta == '0) begin
        s1_num_hue <= '0;
        s1_den_hue <= rhc_pkg::CHAN_W'(1);
      end else begin
        s1_num_hue <= rhc_pkg::NUM_W'(rhc_pkg::HUE_SIXTY) * rhc_pkg::NUM_W'(s0_abs);
        s1_den_hue <= s0_delta;
      end
      s1_side.sector  <= s0_sect;
      s1_side.neg     <= s0_neg;
      s1_side.defined <= s0_delta != '0;
      s1_side.bright  <= s0_mx;
    end
  end

  rhc_div u_div (
    .clk        (clk),
    .en         (en[rhc_pkg::DIV_STAGES+1:2]),
    .num_sat    (s1_num_sat),
    .den_sat    (s1_den_sat),
    .num_hue    (s1_num_hue),
    .den_hue    (s1_den_hue),
    .side_in    (s1_side),
    .quo_sat    (quo_sat),
    .quo_hue    (quo_hue),
    .rem_hue_nz (rem_hue_nz),
    .side_out   (dv_side)
  );

  always_comb begin
    unique case (dv_side.sector)
      rhc_pkg::SECT_RED:   base = '0;
      rhc_pkg::SECT_GREEN: base = rhc_pkg::HUE_CALC_W'(rhc_pkg::HUE_GREEN);
      rhc_pkg::SECT_BLUE:  base = rhc_pkg::HUE_CALC_W'(rhc_pkg::HUE_BLUE);
      default:             base = '0;
    endcase
    if (dv_side.neg) begin
      frac = -($signed(rhc_pkg::HUE_CALC_W'(quo_hue)) +
               $signed(rhc_pkg::HUE_CALC_W'(rem_hue_nz)));
    end else begin
      frac = $signed(rhc_pkg::HUE_CALC_W'(quo_hue));
    end
    hue_sum = base + frac;
    if (hue_sum < 0) begin
      hue_fix = hue_sum + rhc_pkg::HUE_CALC_W'(rhc_pkg::HUE_TURN);
    end else begin
      hue_fix = hue_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      hue         <= dv_side.defined ? hue_fix[rhc_pkg::HUE_W-1:0] : '0;
      saturation  <= quo_sat[rhc_pkg::CHAN_W-1:0];
      brightness  <= dv_side.bright;
      hue_defined <= dv_side.defined;
    end
  end

  `ASSERT_NEXT(a_accept_fills_first, clk, rst, pixel_valid && !pixel_stall, vld[0])
  `ASSERT_IMPL(a_undef_hue_zero, clk, rst, hsv_valid && !hue_defined, hue == '0)
  `ASSERT_IMPL(a_undef_sat_zero, clk, rst, hsv_valid && !hue_defined, saturation == '0)
  `ASSERT_IMPL(a_hue_range, clk, rst, hsv_valid, hue < rhc_pkg::HUE_W'(rhc_pkg::HUE_TURN))
  `ASSERT_IMPL(a_black_sat, clk, rst, hsv_valid && brightness == '0, saturation == '0)

endmodule

`default_nettype wire

// ----- bench/rgb_to_hsv_convert_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_test
// self-checking bench for the rgb to hsv pixel converter
// ----------------------------------------------------------------------------
// Drives pixels through the valid/stall input channel and predicts hue,
// saturation, brightness and hue_defined for each accepted beat. Results are
// matched in order against the predictions. Directed pixels cover black, gray,
// white, primaries, tied maxima and hue wrap; random pixels follow under
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_test;

  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [rhc_pkg::HUE_W-1:0]  hue;
    logic [rhc_pkg::CHAN_W-1:0] sat;
    logic [rhc_pkg::CHAN_W-1:0] bright;
    logic                       defined;
  } hsv_t;

  logic                       clk;
  logic                       rst;
  logic                       pixel_valid;
  logic                       pixel_stall;
  logic [rhc_pkg::CHAN_W-1:0] red;
  logic [rhc_pkg::CHAN_W-1:0] green;
  logic [rhc_pkg::CHAN_W-1:0] blue;
  logic                       hsv_valid;
  logic                       hsv_stall;
  logic [rhc_pkg::HUE_W-1:0]  hue;
  logic [rhc_pkg::CHAN_W-1:0] saturation;
  logic [rhc_pkg::CHAN_W-1:0] brightness;
  logic                       hue_defined;

  hsv_t pending_hsv[$];
  int   send_idle_pct;
  int   stall_pct;
  int   errors;
  int   quiet_cycles;

  rgb_to_hsv_convert uut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .hsv_valid   (hsv_valid),
    .hsv_stall   (hsv_stall),
    .hue         (hue),
    .saturation  (saturation),
    .brightness  (brightness),
    .hue_defined (hue_defined)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor division of the scaled hue fraction, rounding toward minus infinity
  function automatic int hue_fraction(input int diff, input int delta);
    if (diff >= 0) begin
      return (rhc_pkg::HUE_SIXTY * diff) / delta;
    end
    return -((rhc_pkg::HUE_SIXTY * (-diff) + delta - 1) / delta);
  endfunction

  function automatic hsv_t hsv_of(input logic [rhc_pkg::CHAN_W-1:0] r, g, b);
    hsv_t             res;
    int               ri;
    int               gi;
    int               bi;
    int               top;
    int               bottom;
    int               delta;
    int               angle;
    int               sat_q;
    rhc_pkg::sector_t sect;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    top = ri;
    bottom = ri;
    if (gi > top) top = gi;
    if (bi > top) top = bi;
    if (gi < bottom) bottom = gi;
    if (bi < bottom) bottom = bi;
    delta = top - bottom;
    res = '0;
    res.bright = top[rhc_pkg::CHAN_W-1:0];
    if (top != 0) begin
      sat_q = (rhc_pkg::CHAN_FULL * delta) / top;
      res.sat = sat_q[rhc_pkg::CHAN_W-1:0];
    end
    if (delta != 0) begin
      res.defined = 1'b1;
      if (ri == top) sect = rhc_pkg::SECT_RED;
      else if (gi == top) sect = rhc_pkg::SECT_GREEN;
      else sect = rhc_pkg::SECT_BLUE;
      case (sect)
        rhc_pkg::SECT_RED:   angle = hue_fraction(gi - bi, delta);
        rhc_pkg::SECT_GREEN: angle = rhc_pkg::HUE_GREEN + hue_fraction(bi - ri, delta);
        default:             angle = rhc_pkg::HUE_BLUE + hue_fraction(ri - gi, delta);
      endcase
      if (angle < 0) angle += rhc_pkg::HUE_TURN;
      res.hue = angle[rhc_pkg::HUE_W-1:0];
    end
    return res;
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_pixel(input logic [rhc_pkg::CHAN_W-1:0] r, g, b);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    red         <= r;
    green       <= g;
    blue        <= b;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    pending_hsv = {pending_hsv, hsv_of(r, g, b)};
  endtask

  task automatic wait_drained();
    pixel_valid <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk);
  endtask

  task automatic test_black_gray_white();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
  endtask

  task automatic test_primaries();
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd170, 8'd85, 8'd0);
  endtask

  task automatic test_tied_max();
    send_pixel(8'd200, 8'd200, 8'd10);
    send_pixel(8'd10, 8'd200, 8'd200);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd1, 8'd0, 8'd1);
  endtask

  task automatic test_hue_wrap();
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd254, 8'd1, 8'd127);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd2, 8'd0, 8'd1);
  endtask

  // sender holds off until the pipeline has fully emptied
  task automatic test_drain_pause();
    int k;
    for (k = 0; k < 6; k++) begin
      send_pixel(rhc_pkg::CHAN_W'($urandom_range(255)),
                 rhc_pkg::CHAN_W'($urandom_range(255)),
                 rhc_pkg::CHAN_W'($urandom_range(255)));
    end
    wait_drained();
    @(posedge clk);
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    int                         k;
    int                         base;
    int                         pick;
    logic [rhc_pkg::CHAN_W-1:0] r;
    logic [rhc_pkg::CHAN_W-1:0] g;
    logic [rhc_pkg::CHAN_W-1:0] b;
    send_idle_pct = idle;
    stall_pct     = stall;
    for (k = 0; k < count; k++) begin
      r = rhc_pkg::CHAN_W'($urandom_range(255));
      g = rhc_pkg::CHAN_W'($urandom_range(255));
      b = rhc_pkg::CHAN_W'($urandom_range(255));
      case ($urandom_range(9))
        0: begin
          g = r;
          b = r;
        end
        1: begin
          base = $urandom_range(255, 1);
          pick = $urandom_range(2);
          r = rhc_pkg::CHAN_W'(base);
          g = rhc_pkg::CHAN_W'(base);
          b = rhc_pkg::CHAN_W'(base);
          case (pick)
            0: r = rhc_pkg::CHAN_W'($urandom_range(base - 1));
            1: g = rhc_pkg::CHAN_W'($urandom_range(base - 1));
            default: b = rhc_pkg::CHAN_W'($urandom_range(base - 1));
          endcase
        end
        2: begin
          base = $urandom_range(253);
          r = rhc_pkg::CHAN_W'(base + $urandom_range(2));
          g = rhc_pkg::CHAN_W'(base + $urandom_range(2));
          b = rhc_pkg::CHAN_W'(base + $urandom_range(2));
        end
        3: begin
          r = $urandom_range(1) ? 8'd255 : 8'd0;
          g = $urandom_range(1) ? 8'd255 : 8'd0;
          b = $urandom_range(1) ? 8'd255 : rhc_pkg::CHAN_W'($urandom_range(255));
        end
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  always @(posedge clk) begin
    hsv_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_hsv
    hsv_t want;
    if (!rst) begin
      if ((pixel_valid && !pixel_stall) || (hsv_valid && !hsv_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL rgb_to_hsv_convert");
        $finish;
      end else if (hsv_valid && !hsv_stall) begin
        if (pending_hsv.size() == 0) begin
          $error("result beat with no pixel outstanding");
          errors++;
        end else begin
          want = pending_hsv.pop_front();
          if (hue !== want.hue) begin
            $error("hue expected %0d got %0d", want.hue, hue);
            errors++;
          end
          if (saturation !== want.sat) begin
            $error("saturation expected %0d got %0d", want.sat, saturation);
            errors++;
          end
          if (brightness !== want.bright) begin
            $error("brightness expected %0d got %0d", want.bright, brightness);
            errors++;
          end
          if (hue_defined !== want.defined) begin
            $error("hue_defined expected %0d got %0d", want.defined, hue_defined);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    send_idle_pct = 0;
    stall_pct     = 0;
    rst         <= 1'b1;
    pixel_valid <= 1'b0;
    red         <= '0;
    green       <= '0;
    blue        <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_black_gray_white();
    test_primaries();
    test_tied_max();
    test_hue_wrap();
    test_drain_pause();
    test_random(206, 0, 0);
    test_random(206, 55, 0);
    test_random(206, 0, 55);
    test_random(206, 9, 9);

    wait_drained();
    repeat (rhc_pkg::PIPE_STAGES + 8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS rgb_to_hsv_convert");
    end else begin
      $display("FAIL rgb_to_hsv_convert");
    end
    $finish;
  end

endmodule
